>>> hw/rtl/vfs_pkg.sv
// vfs_pkg: shared types and constants of the video frame selector
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package vfs_pkg;

	localparam int LEAD_W = 20;
	localparam int CNT_OUT_W = 9;
	localparam int IDX_OUT_W = 8;
	localparam int LATE_W = 63;

	localparam logic [LEAD_W-1:0] LEAD_LIMIT = LEAD_W'(1000000);
	localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_CONFIG   = 2'd1,
		ST_BAD_TIMELINE = 2'd2
	} status_t;

	// one frame beat after the input register, with the batch values precomputed
	typedef struct packed {
		logic [63:0] media_clock;
		logic [63:0] wanted_gen;
		logic [63:0] frame_gen;
		logic [63:0] pts;
		logic        dur_neg;
		logic        no_frame;
		logic        last;
		logic [63:0] deadline;
		logic        cfg_bad;
	} item_t;

	typedef struct packed {
		status_t              status;
		logic [CNT_OUT_W-1:0] taken_count;
		logic                 has_present;
		logic [IDX_OUT_W-1:0] shown_index;
		logic [CNT_OUT_W-1:0] dropped_count;
		logic [CNT_OUT_W-1:0] stale_count;
		logic [LATE_W-1:0]    lateness_us;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/vfs_ingress.sv
// vfs_ingress: input register of the frame selector with deadline precompute
// depends on vfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module vfs_ingress (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [63:0]                clock_now_us,
	input  wire logic [63:0]                wanted_generation,
	input  wire logic [63:0]                frame_generation,
	input  wire logic [63:0]                frame_pts_us,
	input  wire logic [63:0]                frame_duration_us,
	input  wire logic                       no_frame,
	input  wire logic                       last,
	input  wire logic [vfs_pkg::LEAD_W-1:0] lead_q,
	input  wire logic                       take,
	output logic                            valid_s1,
	output vfs_pkg::item_t                  item_s1
);

	logic [63:0]    sum;
	vfs_pkg::item_t item_d;

	assign in_ready = !valid_s1 || take;

	always_comb begin
		sum = clock_now_us + 64'(lead_q);
		item_d.media_clock = clock_now_us;
		item_d.wanted_gen  = wanted_generation;
		item_d.frame_gen   = frame_generation;
		item_d.pts         = frame_pts_us;
		item_d.dur_neg     = frame_duration_us[63];
		item_d.no_frame    = no_frame;
		item_d.last        = last;
		// clock is non-negative whenever this is used, so overflow shows in the sign bit
		item_d.deadline    = sum[63] ? vfs_pkg::I64_MAX : sum;
		item_d.cfg_bad     = (wanted_generation == 64'd0) || clock_now_us[63] ||
			(lead_q > vfs_pkg::LEAD_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/vfs_scan.sv
// vfs_scan: batch scan state and result register of the frame selector
// depends on vfs_pkg; fed by vfs_ingress
`timescale 1ns / 1ps
`default_nettype none

module vfs_scan #(
	parameter int MAX_FRAMES = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s1,
	input  wire vfs_pkg::item_t  item_s1,
	output logic                 take,
	output logic                 res_valid_s2,
	input  wire logic            res_ready,
	output vfs_pkg::result_t     res_s2
);

	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int DROP_W = CNT_W + 1;

	logic              in_batch_q;
	logic [63:0]       clock_q;
	logic [63:0]       gen_q;
	logic [63:0]       deadline_q;
	logic              cfg_bad_q;
	logic              tl_bad_q;
	logic              stopped_q;
	logic              have_prior_q;
	logic [63:0]       prior_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  stale_q;
	logic [CNT_W-1:0]  elig_q;
	logic              chosen_q;
	logic [SLOT_W-1:0] slot_q;
	logic [63:0]       chosen_pts_q;

	logic [63:0]       clock_e;
	logic [63:0]       gen_e;
	logic [63:0]       deadline_e;
	logic              cfg_bad_e;
	logic              tl_bad_d;
	logic              stopped_d;
	logic              have_prior_d;
	logic [63:0]       prior_d;
	logic [CNT_W-1:0]  pos_d;
	logic [CNT_W-1:0]  stale_d;
	logic [CNT_W-1:0]  elig_d;
	logic              chosen_d;
	logic [SLOT_W-1:0] slot_d;
	logic [63:0]       chosen_pts_d;
	logic              frame_live;
	logic [63:0]       late_diff;
	logic [DROP_W-1:0] dropped;
	vfs_pkg::result_t  res_d;

	assign take = valid_s1 && (!item_s1.last || !res_valid_s2 || res_ready);

	always_comb begin
		clock_e    = in_batch_q ? clock_q : item_s1.media_clock;
		gen_e      = in_batch_q ? gen_q : item_s1.wanted_gen;
		deadline_e = in_batch_q ? deadline_q : item_s1.deadline;
		cfg_bad_e  = in_batch_q ? cfg_bad_q : item_s1.cfg_bad;

		tl_bad_d     = tl_bad_q;
		stopped_d    = stopped_q;
		have_prior_d = have_prior_q;
		prior_d      = prior_q;
		pos_d        = pos_q;
		stale_d      = stale_q;
		elig_d       = elig_q;
		chosen_d     = chosen_q;
		slot_d       = slot_q;
		chosen_pts_d = chosen_pts_q;

		frame_live = !item_s1.no_frame && !cfg_bad_e && !tl_bad_q && !stopped_q &&
			(pos_q != CNT_W'(MAX_FRAMES));
		if (frame_live) begin
			pos_d = pos_q + CNT_W'(1);
			if (item_s1.frame_gen != gen_e) begin
				stale_d = stale_q + CNT_W'(1);
			end else if (item_s1.pts[63] || item_s1.dur_neg ||
				(have_prior_q && (item_s1.pts < prior_q))) begin
				tl_bad_d = 1'b1;
			end else begin
				have_prior_d = 1'b1;
				prior_d      = item_s1.pts;
				if (item_s1.pts > deadline_e) begin
					stopped_d = 1'b1;
				end else begin
					elig_d       = elig_q + CNT_W'(1);
					chosen_d     = 1'b1;
					slot_d       = pos_q[SLOT_W-1:0];
					chosen_pts_d = item_s1.pts;
				end
			end
		end

		// both operands are non-negative, so a set sign bit means pts is later
		late_diff = clock_e - chosen_pts_d;
		dropped   = DROP_W'(stale_d) +
			((elig_d > CNT_W'(1)) ? DROP_W'(elig_d - CNT_W'(1)) : DROP_W'(0));

		res_d = '0;
		if (cfg_bad_e) begin
			res_d.status = vfs_pkg::ST_BAD_CONFIG;
		end else if (tl_bad_d) begin
			res_d.status = vfs_pkg::ST_BAD_TIMELINE;
		end else begin
			res_d.status        = vfs_pkg::ST_OK;
			res_d.taken_count   = vfs_pkg::CNT_OUT_W'(DROP_W'(stale_d) + DROP_W'(elig_d));
			res_d.has_present   = chosen_d;
			res_d.shown_index   = chosen_d ? vfs_pkg::IDX_OUT_W'(slot_d) :
				vfs_pkg::IDX_OUT_W'(0);
			res_d.dropped_count = vfs_pkg::CNT_OUT_W'(dropped);
			res_d.stale_count   = vfs_pkg::CNT_OUT_W'(stale_d);
			res_d.lateness_us   = (chosen_d && !late_diff[63]) ?
				late_diff[vfs_pkg::LATE_W-1:0] : vfs_pkg::LATE_W'(0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_batch_q   <= 1'b0;
			clock_q      <= '0;
			gen_q        <= '0;
			deadline_q   <= '0;
			cfg_bad_q    <= 1'b0;
			tl_bad_q     <= 1'b0;
			stopped_q    <= 1'b0;
			have_prior_q <= 1'b0;
			prior_q      <= '0;
			pos_q        <= '0;
			stale_q      <= '0;
			elig_q       <= '0;
			chosen_q     <= 1'b0;
			slot_q       <= '0;
			chosen_pts_q <= '0;
		end else if (take) begin
			if (item_s1.last) begin
				in_batch_q   <= 1'b0;
				clock_q      <= '0;
				gen_q        <= '0;
				deadline_q   <= '0;
				cfg_bad_q    <= 1'b0;
				tl_bad_q     <= 1'b0;
				stopped_q    <= 1'b0;
				have_prior_q <= 1'b0;
				prior_q      <= '0;
				pos_q        <= '0;
				stale_q      <= '0;
				elig_q       <= '0;
				chosen_q     <= 1'b0;
				slot_q       <= '0;
				chosen_pts_q <= '0;
			end else begin
				in_batch_q   <= 1'b1;
				clock_q      <= clock_e;
				gen_q        <= gen_e;
				deadline_q   <= deadline_e;
				cfg_bad_q    <= cfg_bad_e;
				tl_bad_q     <= tl_bad_d;
				stopped_q    <= stopped_d;
				have_prior_q <= have_prior_d;
				prior_q      <= prior_d;
				pos_q        <= pos_d;
				stale_q      <= stale_d;
				elig_q       <= elig_d;
				chosen_q     <= chosen_d;
				slot_q       <= slot_d;
				chosen_pts_q <= chosen_pts_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (take && item_s1.last) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last) begin
			res_s2 <= res_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/video_frame_selector_core.sv
// video_frame_selector_core: one input register, scan logic, one result register
// result: registered when the scan logic takes the last frame beat of a batch
// throughput: one frame beat per cycle, held only while a finished result is not taken
// reset: arst_n clears the lead register, the batch state and both valid flags
// depends on vfs_pkg, vfs_ingress and vfs_scan
`timescale 1ns / 1ps
`default_nettype none

module video_frame_selector_core #(
	parameter int MAX_FRAMES = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [vfs_pkg::LEAD_W-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [63:0]                   clock_now_us,
	input  wire logic [63:0]                   wanted_generation,
	input  wire logic [63:0]                   frame_generation,
	input  wire logic [63:0]                   frame_pts_us,
	input  wire logic [63:0]                   frame_duration_us,
	input  wire logic                          no_frame,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         status,
	output logic [vfs_pkg::CNT_OUT_W-1:0]      taken_count,
	output logic                               has_present,
	output logic [vfs_pkg::IDX_OUT_W-1:0]      shown_index,
	output logic [vfs_pkg::CNT_OUT_W-1:0]      dropped_count,
	output logic [vfs_pkg::CNT_OUT_W-1:0]      stale_count,
	output logic [vfs_pkg::LATE_W-1:0]         lateness_us
);

	logic [vfs_pkg::LEAD_W-1:0] lead_q;
	logic                       valid_s1;
	logic                       take;
	vfs_pkg::item_t             item_s1;
	vfs_pkg::result_t           res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
		end else if (cfg_wr_en) begin
			lead_q <= cfg_wr_data;
		end
	end

	vfs_ingress u_ingress (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.clock_now_us      (clock_now_us),
		.wanted_generation (wanted_generation),
		.frame_generation  (frame_generation),
		.frame_pts_us      (frame_pts_us),
		.frame_duration_us (frame_duration_us),
		.no_frame          (no_frame),
		.last              (last),
		.lead_q            (lead_q),
		.take              (take),
		.valid_s1          (valid_s1),
		.item_s1           (item_s1)
	);

	vfs_scan #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.take         (take),
		.res_valid_s2 (out_valid),
		.res_ready    (out_ready),
		.res_s2       (res_s2)
	);

	assign status        = res_s2.status;
	assign taken_count   = res_s2.taken_count;
	assign has_present   = res_s2.has_present;
	assign shown_index   = res_s2.shown_index;
	assign dropped_count = res_s2.dropped_count;
	assign stale_count   = res_s2.stale_count;
	assign lateness_us   = res_s2.lateness_us;

endmodule

`default_nettype wire

>>> hw/rtl/vfs_checker.sv
// vfs_checker: port-level checks on result beats of the frame selector
// depends on vfs_pkg; bound to video_frame_selector_core
`timescale 1ns / 1ps
`default_nettype none

module vfs_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [1:0]                    status,
	input wire logic [vfs_pkg::CNT_OUT_W-1:0] taken_count,
	input wire logic                          has_present,
	input wire logic [vfs_pkg::IDX_OUT_W-1:0] shown_index,
	input wire logic [vfs_pkg::CNT_OUT_W-1:0] dropped_count,
	input wire logic [vfs_pkg::CNT_OUT_W-1:0] stale_count,
	input wire logic [vfs_pkg::LATE_W-1:0]    lateness_us
);

	// stalled result beat holds its valid flag, status, taken count and lateness
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(taken_count) && $stable(lateness_us))
		else $error("result beat changed while stalled");

	// error status carries no counts
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != vfs_pkg::ST_OK) |->
			taken_count == '0 && !has_present && shown_index == '0 &&
			dropped_count == '0 && stale_count == '0 && lateness_us == '0)
		else $error("error result with nonzero fields");

	// no chosen frame means no index and no lateness
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_present |-> shown_index == '0 && lateness_us == '0)
		else $error("index or lateness without chosen frame");

	// no eligible frame in an OK result means every consumed frame was stale
	a_none_stale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_present && (status == vfs_pkg::ST_OK) |->
			dropped_count == stale_count && taken_count == stale_count)
		else $error("counts disagree without chosen frame");

endmodule

bind video_frame_selector_core vfs_checker u_vfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.taken_count   (taken_count),
	.has_present   (has_present),
	.shown_index   (shown_index),
	.dropped_count (dropped_count),
	.stale_count   (stale_count),
	.lateness_us   (lateness_us)
);

`default_nettype wire
